[hdl/rlc_pkg.sv]
// Shared types, widths and the helper function of the rectangle line clipper.
// Used by every module of the clipper; depends on nothing.
package rlc_pkg;

  localparam int CW  = 16;  // coordinate width
  localparam int DW  = 17;  // width of a coordinate difference
  localparam int PW  = 34;  // width of a 17 x 17 product
  localparam int NW  = 36;  // width of a crossing numerator
  localparam int QD  = 4;   // depth of the front-to-back queue
  localparam int QAW = 2;   // queue pointer width
  localparam int QCW = 3;   // queue fill count width

  // Outcode bits.
  localparam int BIT_LEFT   = 0;
  localparam int BIT_RIGHT  = 1;
  localparam int BIT_BOTTOM = 2;
  localparam int BIT_TOP    = 3;

  // Configuration register indexes.
  localparam logic [2:0] REG_LEFT   = 3'd0;
  localparam logic [2:0] REG_RIGHT  = 3'd1;
  localparam logic [2:0] REG_BOTTOM = 3'd2;
  localparam logic [2:0] REG_TOP    = 3'd3;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [DW-1:0] delta_t;
  typedef logic signed [NW-1:0] num_t;

  typedef struct packed {
    coord_t left;
    coord_t right;
    coord_t bottom;
    coord_t top;
  } win_t;

  // Crossing numerators of one endpoint, one per window edge.
  typedef struct packed {
    num_t l;
    num_t r;
    num_t b;
    num_t t;
  } nums_t;

  // Segment facts that travel alongside the divisions.
  typedef struct packed {
    logic       trivial_rej;
    logic [3:0] ca;
    logic [3:0] cb;
    coord_t     ax;
    coord_t     ay;
    coord_t     bx;
    coord_t     by;
    logic       dx_zero;
    logic       dy_zero;
  } seg_t;

  // One queue entry: a classified segment ready for division.
  typedef struct packed {
    seg_t   seg;
    delta_t dx;
    delta_t dy;
    nums_t  na;
    nums_t  nb;
  } qent_t;

  // Four-bit region code of a point.
  function automatic logic [3:0] outcode(input coord_t x, input coord_t y, input win_t w);
    logic [3:0] c;
    c             = '0;
    c[BIT_LEFT]   = x < w.left;
    c[BIT_RIGHT]  = x > w.right;
    c[BIT_BOTTOM] = y < w.bottom;
    c[BIT_TOP]    = y > w.top;
    return c;
  endfunction

endpackage

[hdl/rlc_front.sv]
// Front end of the clipper: takes segment beats, forms outcodes, differences and
// the crossing numerators in two register stages. Depends on rlc_pkg.
module rlc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [63:0]        in_tdata,  // start_x, start_y, end_x, end_y
  input  rlc_pkg::win_t      win,
  input  logic [2:0]         q_count,
  output logic               wr_valid,
  output rlc_pkg::qent_t     wr_data
);
  import rlc_pkg::*;

  logic   v1_r, v2_r;
  seg_t   seg1_r, seg2_r;
  delta_t dx1_r, dy1_r, ndx1_r, ndy1_r;
  delta_t dal_r, dar_r, dab_r, dat_r, dbl_r, dbr_r, dbb_r, dbt_r;
  delta_t dx2_r, dy2_r;
  logic signed [PW-1:0] pay_r, pax_r, pby_r, pbx_r;
  logic signed [PW-1:0] pal_r, par_r, pab_r, pat_r, pbl_r, pbr_r, pbb_r, pbt_r;
  coord_t ax, ay, bx, by;
  delta_t dx, dy;
  seg_t   seg;
  logic   acc;

  assign ax = in_tdata[15:0];
  assign ay = in_tdata[31:16];
  assign bx = in_tdata[47:32];
  assign by = in_tdata[63:48];
  assign dx = DW'(bx) - DW'(ax);
  assign dy = DW'(by) - DW'(ay);

  // Credit check: every item in flight in the front owns a queue slot.
  assign in_tready = (q_count + QCW'(v1_r) + QCW'(v2_r)) < QCW'(QD);
  assign acc       = in_tvalid && in_tready;

  // Classification of the incoming segment.
  always_comb begin
    seg.ca          = outcode(ax, ay, win);
    seg.cb          = outcode(bx, by, win);
    seg.trivial_rej = (seg.ca & seg.cb) != 4'd0;
    seg.ax          = ax;
    seg.ay          = ay;
    seg.bx          = bx;
    seg.by          = by;
    seg.dx_zero     = dx == '0;
    seg.dy_zero     = dy == '0;
  end

  // Valid bits of the two front stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= acc;
      v2_r <= v1_r;
    end
  end

  // Stage one: differences to the endpoints and to the window edges.
  always_ff @(posedge clk) begin
    seg1_r <= seg;
    dx1_r  <= dx;
    dy1_r  <= dy;
    ndx1_r <= -dx;
    ndy1_r <= -dy;
    dal_r  <= DW'(win.left) - DW'(ax);
    dar_r  <= DW'(win.right) - DW'(ax);
    dab_r  <= DW'(win.bottom) - DW'(ay);
    dat_r  <= DW'(win.top) - DW'(ay);
    dbl_r  <= DW'(win.left) - DW'(bx);
    dbr_r  <= DW'(win.right) - DW'(bx);
    dbb_r  <= DW'(win.bottom) - DW'(by);
    dbt_r  <= DW'(win.top) - DW'(by);
  end

  // Stage two: the products of the crossing numerators.
  always_ff @(posedge clk) begin
    seg2_r <= seg1_r;
    dx2_r  <= dx1_r;
    dy2_r  <= dy1_r;
    pay_r  <= DW'(seg1_r.ay) * dx1_r;
    pax_r  <= DW'(seg1_r.ax) * dy1_r;
    pby_r  <= DW'(seg1_r.by) * ndx1_r;
    pbx_r  <= DW'(seg1_r.bx) * ndy1_r;
    pal_r  <= dal_r * dy1_r;
    par_r  <= dar_r * dy1_r;
    pab_r  <= dab_r * dx1_r;
    pat_r  <= dat_r * dx1_r;
    pbl_r  <= dbl_r * ndy1_r;
    pbr_r  <= dbr_r * ndy1_r;
    pbb_r  <= dbb_r * ndx1_r;
    pbt_r  <= dbt_r * ndx1_r;
  end

  // Numerator sums go straight into the queue.
  assign wr_valid = v2_r;
  always_comb begin
    wr_data.seg  = seg2_r;
    wr_data.dx   = dx2_r;
    wr_data.dy   = dy2_r;
    wr_data.na.l = NW'(pay_r) + NW'(pal_r);
    wr_data.na.r = NW'(pay_r) + NW'(par_r);
    wr_data.na.b = NW'(pax_r) + NW'(pab_r);
    wr_data.na.t = NW'(pax_r) + NW'(pat_r);
    wr_data.nb.l = NW'(pby_r) + NW'(pbl_r);
    wr_data.nb.r = NW'(pby_r) + NW'(pbr_r);
    wr_data.nb.b = NW'(pbx_r) + NW'(pbb_r);
    wr_data.nb.t = NW'(pbx_r) + NW'(pbt_r);
  end

endmodule

[hdl/rlc_queue.sv]
// Short queue between the clipper's front and back ends.
// Depends on rlc_pkg.
module rlc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  input  rlc_pkg::qent_t  wr_data,
  input  logic            rd_pop,
  output logic            rd_valid,
  output rlc_pkg::qent_t  rd_data,
  output logic [2:0]      count
);
  import rlc_pkg::*;

  qent_t           mem_r [QD];
  logic [QAW-1:0]  wp_r, rp_r;
  logic [QCW-1:0]  cnt_r;

  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem_r[rp_r];
  assign count    = cnt_r;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_valid) wp_r <= wp_r + 1'b1;
      if (rd_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + QCW'(wr_valid) - QCW'(rd_pop);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (wr_valid) mem_r[wp_r] <= wr_data;
  end

endmodule

[hdl/rlc_div.sv]
// Pipelined restoring divider, one quotient bit per stage, truncating toward zero.
// Used by the clipper's back end; depends on rlc_pkg.
module rlc_div (
  input  logic                    clk,
  input  logic                    en,
  input  rlc_pkg::num_t           num,
  input  rlc_pkg::delta_t         den,
  output logic signed [rlc_pkg::NW:0] quo
);
  import rlc_pkg::*;

  logic [NW-1:0] nq_r  [NW+1];
  logic [15:0]   rem_r [NW+1];
  logic [15:0]   d_r   [NW+1];
  logic          neg_r [NW+1];
  logic [NW-1:0] nmag;
  logic [DW-1:0] dmag;

  assign nmag = num[NW-1] ? NW'(-num) : NW'(num);
  assign dmag = den[DW-1] ? DW'(-den) : DW'(den);

  // Entry stage: magnitudes and result sign.
  always_ff @(posedge clk) begin
    if (en) begin
      nq_r[0]  <= nmag;
      rem_r[0] <= '0;
      d_r[0]   <= dmag[15:0];
      neg_r[0] <= num[NW-1] ^ den[DW-1];
    end
  end

  // One compare and subtract per stage.
  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [16:0] rs, diff;
    logic        ge;
    assign rs   = {rem_r[k], nq_r[k][NW-1]};
    assign ge   = rs >= {1'b0, d_r[k]};
    assign diff = rs - {1'b0, d_r[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge ? diff[15:0] : rs[15:0];
        nq_r[k+1]  <= {nq_r[k][NW-2:0], ge};
        d_r[k+1]   <= d_r[k];
        neg_r[k+1] <= neg_r[k];
      end
    end
  end

  assign quo = neg_r[NW] ? -$signed({1'b0, nq_r[NW]}) : $signed({1'b0, nq_r[NW]});

endmodule

[hdl/rlc_back.sv]
// Back end of the clipper: eight crossing divisions, edge selection per endpoint
// and the output register. Depends on rlc_pkg and rlc_div.
module rlc_back (
  input  logic            clk,
  input  logic            rst_n,
  input  rlc_pkg::win_t   win,
  input  logic            q_valid,
  input  rlc_pkg::qent_t  q_data,
  output logic            q_pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [63:0]     out_tdata,  // clip_x0, clip_y0, clip_x1, clip_y1
  output logic            out_tuser   // visible
);
  import rlc_pkg::*;

  typedef struct packed {
    logic   found;
    coord_t x;
    coord_t y;
  } pt_t;

  typedef logic signed [NW:0] quo_t;

  logic   en;
  logic   v_r  [NW+1];
  seg_t   pl_r [NW+1];
  logic   out_valid_r, vis_r;
  coord_t x0_r, y0_r, x1_r, y1_r;
  quo_t   qal, qar, qab, qat, qbl, qbr, qbb, qbt;
  delta_t ndx, ndy;
  pt_t    pa, pb;
  seg_t   s;
  logic   vis;

  // The whole back pipeline holds while a finished result is not taken.
  assign en    = !out_valid_r || out_tready;
  assign q_pop = en && q_valid;
  assign ndx   = -q_data.dx;
  assign ndy   = -q_data.dy;

  rlc_div u_div_al (.clk, .en, .num(q_data.na.l), .den(q_data.dx), .quo(qal));
  rlc_div u_div_ar (.clk, .en, .num(q_data.na.r), .den(q_data.dx), .quo(qar));
  rlc_div u_div_ab (.clk, .en, .num(q_data.na.b), .den(q_data.dy), .quo(qab));
  rlc_div u_div_at (.clk, .en, .num(q_data.na.t), .den(q_data.dy), .quo(qat));
  rlc_div u_div_bl (.clk, .en, .num(q_data.nb.l), .den(ndx), .quo(qbl));
  rlc_div u_div_br (.clk, .en, .num(q_data.nb.r), .den(ndx), .quo(qbr));
  rlc_div u_div_bb (.clk, .en, .num(q_data.nb.b), .den(ndy), .quo(qbb));
  rlc_div u_div_bt (.clk, .en, .num(q_data.nb.t), .den(ndy), .quo(qbt));

  // Segment facts and valid bits ride along with the dividers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= NW; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= q_valid;
      for (int k = 1; k <= NW; k++) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl_r[0] <= q_data.seg;
      for (int k = 1; k <= NW; k++) pl_r[k] <= pl_r[k-1];
    end
  end

  // Own point if inside; else first outcode edge (L, R, B, T order) crossing the window.
  function automatic pt_t pick(input logic [3:0] c, input coord_t px, input coord_t py,
                               input quo_t ql, input quo_t qr, input quo_t qb,
                               input quo_t qt, input logic dxz, input logic dyz,
                               input win_t w);
    pt_t p;
    p.found = 1'b0;
    p.x     = px;
    p.y     = py;
    if (c == 4'd0) begin
      p.found = 1'b1;
    end else if (c[BIT_LEFT] && !dxz && ql >= w.bottom && ql <= w.top) begin
      p = '{1'b1, w.left, ql[CW-1:0]};
    end else if (c[BIT_RIGHT] && !dxz && qr >= w.bottom && qr <= w.top) begin
      p = '{1'b1, w.right, qr[CW-1:0]};
    end else if (c[BIT_BOTTOM] && !dyz && qb >= w.left && qb <= w.right) begin
      p = '{1'b1, qb[CW-1:0], w.bottom};
    end else if (c[BIT_TOP] && !dyz && qt >= w.left && qt <= w.right) begin
      p = '{1'b1, qt[CW-1:0], w.top};
    end
    return p;
  endfunction

  assign s   = pl_r[NW];
  assign pa  = pick(s.ca, s.ax, s.ay, qal, qar, qab, qat, s.dx_zero, s.dy_zero, win);
  assign pb  = pick(s.cb, s.bx, s.by, qbl, qbr, qbb, qbt, s.dx_zero, s.dy_zero, win);
  assign vis = !s.trivial_rej && pa.found && pb.found;

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v_r[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vis_r <= vis;
      x0_r  <= vis ? pa.x : '0;
      y0_r  <= vis ? pa.y : '0;
      x1_r  <= vis ? pb.x : '0;
      y1_r  <= vis ? pb.y : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = vis_r;
  assign out_tdata  = {y1_r, x1_r, y0_r, x0_r};

endmodule

[hdl/rect_line_clipper_top.sv]
// Top level of the rectangle line clipper: window registers, front end, queue, back end.
// Depends on rlc_pkg, rlc_front, rlc_queue, rlc_back and rlc_div.
//
//  Channel  Direction  Beat contents
//  in_      slave      tdata = start_x, start_y, end_x, end_y (16 bits each, low first)
//  out_     master     tdata = clip_x0, clip_y0, clip_x1, clip_y1; tuser = visible
//  cfg_     slave      index 0..3 = left, right, bottom, top; data = 16-bit edge
//
// While out_tready stays high, one segment per cycle is taken and one result per cycle
// is delivered. A segment passes two front stages, the queue, the divider entry stage,
// 36 divider stages (one quotient bit each) and the output register.
// Reset clears the window to zero and empties all stages; no clearing pass.
// A stalled output holds the back end; the four-entry queue keeps the front moving
// until queued and in-flight segments claim all its entries, then in_tready drops.
module rect_line_clipper_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // start_x, start_y, end_x, end_y
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // clip_x0, clip_y0, clip_x1, clip_y1
  output logic        out_tuser,  // visible
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import rlc_pkg::*;

  win_t       win_r;
  logic       wr_valid, q_valid, q_pop;
  qent_t      wr_data, q_data;
  logic [2:0] q_count;

  // Window registers; writes beyond the list are ignored.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LEFT:   win_r.left   <= cfg_data;
        REG_RIGHT:  win_r.right  <= cfg_data;
        REG_BOTTOM: win_r.bottom <= cfg_data;
        REG_TOP:    win_r.top    <= cfg_data;
        default:    ;
      endcase
    end
  end

  rlc_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .win(win_r), .q_count, .wr_valid, .wr_data
  );

  rlc_queue u_queue (
    .clk, .rst_n, .wr_valid, .wr_data,
    .rd_pop(q_pop), .rd_valid(q_valid), .rd_data(q_data), .count(q_count)
  );

  rlc_back u_back (
    .clk, .rst_n, .win(win_r), .q_valid, .q_data, .q_pop,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );

endmodule

[hdl/rlc_checker.sv]
// Port-level checks of the rectangle line clipper and their bind to the top level.
// Depends only on the top level's ports.
module rlc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic        out_tuser
);

  // An invisible result carries all-zero endpoints.
  a_invis_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 64'd0)
    else $error("invisible result with nonzero endpoints");

  // Coming out of reset the block is empty and ready.
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid && in_tready)
    else $error("block not empty after reset");

  // A stalled result stays put.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // With the output draining, the input side is never held off.
  a_drain_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid && $past(!out_tvalid) && $past(!out_tvalid, 2) && $past(rst_n, 2)
      && $past(!out_tvalid, 3) && $past(rst_n, 3) |-> in_tready || out_tvalid)
    else $error("input stalled while output idle");

endmodule

bind rect_line_clipper_top rlc_checker u_rlc_checker (
  .clk, .rst_n, .in_tready, .out_tvalid, .out_tready, .out_tdata, .out_tuser
);

[tb/sv/rect_line_clipper_top_tb.sv]
// Testbench of the rectangle line clipper: directed and random segments checked
// against a behavioral clipping predictor. Depends on rlc_pkg and rect_line_clipper_top.
`timescale 1ns / 1ps

module rect_line_clipper_top_tb;
  import rlc_pkg::*;

  localparam int N_RANDOM   = 1550;
  localparam int DRAIN_CYC  = 60;

  typedef struct packed {
    logic   vis;
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
  } clip_t;

  typedef struct {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    logic   has_exp;
    clip_t  exp_clip;
  } seg_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic        out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  // Window as the predictor sees it.
  int win_l, win_r, win_b, win_t;

  clip_t clip_queue[$];
  int    n_fail;
  bit    sink_quiet;
  bit    sink_hold;

  rect_line_clipper_top i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [3:0] region_code(longint x, longint y);
    logic [3:0] c;
    c = '0;
    c[BIT_LEFT]   = x < win_l;
    c[BIT_RIGHT]  = x > win_r;
    c[BIT_BOTTOM] = y < win_b;
    c[BIT_TOP]    = y > win_t;
    return c;
  endfunction

  // Moves an outside endpoint onto the first valid edge crossing.
  function automatic bit move_to_edge(logic [3:0] c, ref longint px, ref longint py,
                                      input longint qx, input longint qy);
    longint dx, dy, v;
    dx = qx - px;
    dy = qy - py;
    for (int e = 0; e < 4; e++) begin
      if (!c[e]) continue;
      if (e == BIT_LEFT || e == BIT_RIGHT) begin
        longint ex;
        ex = (e == BIT_LEFT) ? win_l : win_r;
        if (dx == 0) continue;
        v = (py * dx + (ex - px) * dy) / dx;
        if (v >= win_b && v <= win_t) begin
          px = ex;
          py = v;
          return 1'b1;
        end
      end else begin
        longint ey;
        ey = (e == BIT_BOTTOM) ? win_b : win_t;
        if (dy == 0) continue;
        v = (px * dy + (ey - py) * dx) / dy;
        if (v >= win_l && v <= win_r) begin
          px = v;
          py = ey;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic clip_t clip_segment(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    longint ax, ay, bx, by;
    logic [3:0] ca, cb;
    bit vis;
    clip_t r;
    ax = sx; ay = sy; bx = ex; by = ey;
    ca = region_code(ax, ay);
    cb = region_code(bx, by);
    vis = 1'b1;
    if ((ca & cb) != 0) vis = 1'b0;
    else begin
      if (ca != 0 && !move_to_edge(ca, ax, ay, ex, ey)) vis = 1'b0;
      if (vis && cb != 0 && !move_to_edge(cb, bx, by, sx, sy)) vis = 1'b0;
    end
    r.vis = vis;
    r.x0 = vis ? coord_t'(ax) : '0;
    r.y0 = vis ? coord_t'(ay) : '0;
    r.x1 = vis ? coord_t'(bx) : '0;
    r.y1 = vis ? coord_t'(by) : '0;
    return r;
  endfunction

  // Presents one register write; the caller drops cfg_valid after the last one.
  task automatic write_edge(logic [2:0] idx, int value);
    cfg_index <= idx;
    cfg_data  <= value[15:0];
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_LEFT:   win_l = coord_t'(value[15:0]);
      REG_RIGHT:  win_r = coord_t'(value[15:0]);
      REG_BOTTOM: win_b = coord_t'(value[15:0]);
      default:    win_t = coord_t'(value[15:0]);
    endcase
  endtask

  task automatic set_window(int l, int r, int b, int t);
    write_edge(REG_LEFT, l);
    write_edge(REG_RIGHT, r);
    write_edge(REG_BOTTOM, b);
    write_edge(REG_TOP, t);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every expected result has come back.
  task automatic drain_results();
    while (clip_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic send_segment(coord_t ax, coord_t ay, coord_t bx, coord_t by,
                              bit idle_ok, bit has_exp = 0, clip_t exp_clip = '0);
    clip_t pred;
    if (idle_ok && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    pred = clip_segment(ax, ay, bx, by);
    if (has_exp && pred !== exp_clip) begin
      $error("directed row disagrees with predictor: %h vs %h", exp_clip, pred);
      n_fail++;
    end
    in_tdata  <= {by, bx, ay, ax};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    clip_queue.insert(clip_queue.size(), has_exp ? exp_clip : pred);
  endtask

  function automatic coord_t rand_coord(int lo, int hi);
    case ($urandom_range(0, 9))
      0:       return coord_t'($urandom);
      1:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return coord_t'(lo - 40 + int'($urandom_range(0, hi - lo + 80)));
    endcase
  endfunction

  // Output side: random stall bursts, checks each result beat.
  initial begin
    clip_t got, want;
    int    idle_left;
    out_tready = 1'b0;
    idle_left = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        got = {out_tuser, out_tdata[15:0], out_tdata[31:16], out_tdata[47:32],
               out_tdata[63:48]};
        if (clip_queue.size() == 0) begin
          $error("result beat with nothing expected");
          n_fail++;
        end else begin
          want = clip_queue.pop_front();
          if (got.vis !== want.vis) begin
            $error("visible: expected %0d, got %0d", want.vis, got.vis); n_fail++;
          end
          if (got.x0 !== want.x0) begin
            $error("clip_x0: expected %0d, got %0d", want.x0, got.x0); n_fail++;
          end
          if (got.y0 !== want.y0) begin
            $error("clip_y0: expected %0d, got %0d", want.y0, got.y0); n_fail++;
          end
          if (got.x1 !== want.x1) begin
            $error("clip_x1: expected %0d, got %0d", want.x1, got.x1); n_fail++;
          end
          if (got.y1 !== want.y1) begin
            $error("clip_y1: expected %0d, got %0d", want.y1, got.y1); n_fail++;
          end
        end
      end
      if (sink_hold) begin
        out_tready <= 1'b0;
      end else if (idle_left > 0) begin
        idle_left--;
        out_tready <= 1'b0;
      end else if (!sink_quiet && $urandom_range(0, 4) == 0) begin
        idle_left = $urandom_range(0, 5);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  seg_row_t rows[$];

  initial begin
    int lo, hi;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_LEFT;
    cfg_data = '0;
    n_fail = 0;
    sink_quiet = 1'b0;
    sink_hold = 1'b0;
    win_l = 0; win_r = 0; win_b = 0; win_t = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // After reset the window is the single point at the origin.
    rows = '{
      '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1, '{1, 16'sd0, 16'sd0, 16'sd0, 16'sd0}},
      '{16'sd1, 16'sd1, 16'sd5, 16'sd5, 1, '0},
      '{-16'sd3, 16'sd0, 16'sd3, 16'sd0, 1, '{1, 16'sd0, 16'sd0, 16'sd0, 16'sd0}}
    };
    foreach (rows[i])
      send_segment(rows[i].ax, rows[i].ay, rows[i].bx, rows[i].by, 1,
                   rows[i].has_exp, rows[i].exp_clip);
    in_tvalid <= 1'b0;
    drain_results();

    // Ordinary window: inside, trivial reject, one and two crossings, vertical,
    // horizontal, a line that misses the window, extremes.
    set_window(-100, 100, -50, 50);
    rows = '{
      '{16'sd10, 16'sd20, -16'sd30, 16'sd40, 1, '{1, 16'sd10, 16'sd20, -16'sd30, 16'sd40}},
      '{-16'sd200, 16'sd0, -16'sd150, 16'sd10, 1, '0},
      '{16'sd0, 16'sd100, 16'sd10, 16'sd200, 1, '0},
      '{16'sd0, 16'sd0, 16'sd200, 16'sd0, 1, '{1, 16'sd0, 16'sd0, 16'sd100, 16'sd0}},
      '{16'sd5, -16'sd300, 16'sd5, 16'sd300, 1, '{1, 16'sd5, -16'sd50, 16'sd5, 16'sd50}},
      '{-16'sd200, 16'sd7, 16'sd200, 16'sd7, 1, '{1, -16'sd100, 16'sd7, 16'sd100, 16'sd7}},
      '{-16'sd200, 16'sd0, 16'sd0, 16'sd200, 1, '0},
      '{-16'sd300, -16'sd100, 16'sd300, 16'sd100, 0, '0},
      '{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 0, '0},
      '{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 0, '0},
      '{16'sd100, 16'sd50, -16'sd100, -16'sd50, 1, '{1, 16'sd100, 16'sd50, -16'sd100, -16'sd50}},
      '{16'sd3, 16'sd1, 16'sd500, 16'sd2, 0, '0}
    };
    foreach (rows[i])
      send_segment(rows[i].ax, rows[i].ay, rows[i].bx, rows[i].by, 1,
                   rows[i].has_exp, rows[i].exp_clip);
    in_tvalid <= 1'b0;
    drain_results();

    // Extreme and degenerate windows.
    set_window(-32768, 32767, -32768, 32767);
    send_segment(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 0, 1,
                 '{1, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000});
    in_tvalid <= 1'b0;
    drain_results();
    set_window(10, -10, 5, -5);
    send_segment(-16'sd20, 16'sd0, 16'sd20, 16'sd0, 0);
    send_segment(16'sd0, 16'sd0, 16'sd1, 16'sd1, 0);
    in_tvalid <= 1'b0;
    drain_results();

    // Random phases, each with its own window.
    for (int ph = 0; ph < 8; ph++) begin
      int n;
      if (ph == 7) sink_quiet = 1'b1;
      case (ph)
        0: set_window(-32768, 32767, -32768, 32767);
        1: set_window(-1000, 1000, -700, 800);
        2: set_window(3, 3, -4, -4);
        3: set_window(20, -20, 0, 100);
        default: begin
          lo = int'($urandom_range(0, 60000)) - 32768;
          hi = lo + int'($urandom_range(0, 65535 - (lo + 32768)));
          set_window(lo, hi, lo / 2, hi / 2 + int'($urandom_range(0, 100)));
        end
      endcase
      n = N_RANDOM / 8;
      // Long receiver hold-off while the sender keeps offering beats.
      if (ph == 1) begin
        fork
          begin
            sink_hold = 1'b1;
            repeat (200) @(posedge clk);
            sink_hold = 1'b0;
          end
        join_none
      end
      for (int k = 0; k < n; k++) begin
        lo = (ph == 0) ? -32768 : win_l;
        hi = (ph == 0) ? 32767 : win_r;
        if (hi < lo) begin
          int t; t = lo; lo = hi; hi = t;
        end
        if (hi - lo > 60000) begin
          lo = -30000; hi = 30000;
        end
        send_segment(rand_coord(lo, hi), rand_coord(lo, hi),
                     rand_coord(lo, hi), rand_coord(lo, hi), ph != 7);
      end
      in_tvalid <= 1'b0;
      drain_results();
    end

    if (n_fail == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

[filelist.f]
hdl/rlc_pkg.sv
hdl/rlc_front.sv
hdl/rlc_queue.sv
hdl/rlc_div.sv
hdl/rlc_back.sv
hdl/rect_line_clipper_top.sv
hdl/rlc_checker.sv
tb/sv/rect_line_clipper_top_tb.sv
